// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker file of the page allocator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFPA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFPA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page allocator check failed");

`endif

// ===== rtl/ffpa_pkg.sv =====
// Package of the first-fit page allocator: sizes, codes, transaction types and states.
// It depends on nothing; every module file of the block imports it.
package ffpa_pkg;

  localparam int NUM_PAGES = 64;
  localparam int IDX_W     = $clog2(NUM_PAGES);
  localparam int ENT_W     = $clog2(NUM_PAGES + 1);
  localparam int POS_W     = $clog2(2 * NUM_PAGES);
  localparam int PS_W      = 13;
  localparam int BYTES_W   = 20;
  localparam int ADR_W     = 32;
  localparam int LIM_W     = PS_W + IDX_W;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;

  localparam logic [PS_W-1:0] PG_BYTES_RST = PS_W'(64);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_BAD_ADDRESS = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_PG_BYTES     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SCAN,
    S_COMMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADR_W-1:0]   release_address;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [ADR_W-1:0] block_address;
  } out_item_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
  } tbl_req_t;

endpackage

// ===== rtl/ffpa_table.sv =====
// Run table of the page allocator: one synchronous memory with registered read data.
// Per-entry valid bits make every entry read as free after reset. Depends on ffpa_pkg.
module ffpa_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffpa_pkg::tbl_req_t           req,
  output logic [ffpa_pkg::ENT_W-1:0]   rd_data
);
  import ffpa_pkg::*;

  logic [ENT_W-1:0]     mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] vld_r;
  logic [ENT_W-1:0]     rdata_r;
  logic                 rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ===== rtl/ffpa_div.sv =====
// Restoring divider that yields one quotient bit per cycle for a page index.
// The dividend must be below divisor times the page count. Depends on ffpa_pkg.
module ffpa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ffpa_pkg::LIM_W-1:0] dividend,
  input  logic [ffpa_pkg::PS_W-1:0]  divisor,
  output logic                       done,
  output logic [ffpa_pkg::IDX_W-1:0] quotient
);
  import ffpa_pkg::*;

  localparam int STEP_W = $clog2(IDX_W + 1);

  logic [LIM_W-1:0]  rem_r;
  logic [LIM_W-1:0]  dsh_r;
  logic [IDX_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              active_r;
  logic              done_r;
  logic              ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        step_r   <= STEP_W'(IDX_W);
      end else if (active_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= LIM_W'(divisor) << (IDX_W - 1);
      quo_r <= '0;
    end else if (active_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= (quo_r << 1) | IDX_W'(ge);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/ffpa_regs.sv =====
// Configuration registers of the page allocator behind an APB-style port.
// Holds the region base address and the page size. Depends on ffpa_pkg.
module ffpa_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffpa_pkg::CFG_AW-1:0] paddr,
  input  logic [ffpa_pkg::CFG_DW-1:0] pwdata,
  output logic [ffpa_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [ffpa_pkg::ADR_W-1:0]  base_address,
  output logic [ffpa_pkg::PS_W-1:0]   pg_bytes
);
  import ffpa_pkg::*;

  logic [ADR_W-1:0] base_r;
  logic [PS_W-1:0]  psize_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      psize_r <= PG_BYTES_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE_ADDRESS: base_r  <= pwdata[ADR_W-1:0];
        REG_PG_BYTES:     psize_r <= pwdata[PS_W-1:0];
        default:          base_r  <= base_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_ADDRESS: prdata = CFG_DW'(base_r);
      REG_PG_BYTES:     prdata = CFG_DW'(psize_r);
      default:          prdata = '0;
    endcase
  end

  assign base_address = base_r;
  assign pg_bytes     = psize_r;

endmodule

// ===== rtl/first_fit_page_allocator.sv =====
// First-fit page allocator: a free passes the range check, the divider and the table write; an
// allocate also scans the run table entry by entry and commits the run; out-of-range requests skip to the result.
// One transaction is in work at a time; the next is accepted once the result is registered.
// The run-table read port sets the scan rate; the page index takes a 6-step divider.
// Synchronous active-low reset marks every table entry free and restores the registers.
module first_fit_page_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ffpa_pkg::in_item_t          in_payload,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ffpa_pkg::out_item_t         out_payload,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ffpa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ffpa_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ffpa_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import ffpa_pkg::*;

  logic [ADR_W-1:0]       base_address;
  logic [PS_W-1:0]        pg_bytes;
  logic [PS_W-1:0]        ps_eff;
  logic [LIM_W-1:0]       limit;
  logic                   over;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [ADR_W-1:0]       dvd_r, dvd_nxt;
  logic [ENT_W-1:0]       need_r, need_nxt;
  logic [ENT_W-1:0]       cont_r, cont_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  out_item_t              res_r, res_nxt;
  out_item_t              out_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;

  tbl_req_t               tbl_req;
  logic [ENT_W-1:0]       tbl_rdata;
  logic                   div_start;
  logic                   div_done;
  logic [IDX_W-1:0]       div_quo;
  logic [POS_W-1:0]       head_full;
  logic [IDX_W-1:0]       head;
  logic [IDX_W+PS_W-1:0]  head_ofs;

  ffpa_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .base_address (base_address),
    .pg_bytes     (pg_bytes)
  );

  ffpa_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_data (tbl_rdata)
  );

  ffpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r[LIM_W-1:0]),
    .divisor  (ps_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign ps_eff    = (pg_bytes == '0) ? PS_W'(1) : pg_bytes;
  assign limit     = LIM_W'(ps_eff) * LIM_W'(NUM_PAGES);
  assign over      = dvd_r >= ADR_W'(limit);
  assign head_full = pos_r - POS_W'(need_r);
  assign head      = head_full[IDX_W-1:0];
  assign head_ofs  = (IDX_W+PS_W)'(head) * (IDX_W+PS_W)'(ps_eff);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    dvd_nxt   = dvd_r;
    need_nxt  = need_r;
    cont_nxt  = cont_r;
    pos_nxt   = pos_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    tbl_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt = in_payload.operation;
          if (in_payload.operation == OP_FREE) begin
            dvd_nxt = in_payload.release_address - base_address;
          end else begin
            dvd_nxt = ADR_W'(in_payload.request_bytes) - ADR_W'(1);
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (over) begin
          res_nxt.status        = (op_r == OP_FREE) ? ST_BAD_ADDRESS : ST_NO_SPACE;
          res_nxt.block_address = '0;
          state_nxt             = S_RESP;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_r == OP_FREE) begin
            tbl_req.wr_en         = 1'b1;
            tbl_req.wr_addr       = div_quo;
            tbl_req.wr_data       = '0;
            res_nxt.status        = ST_OK;
            res_nxt.block_address = '0;
            state_nxt             = S_RESP;
          end else begin
            need_nxt        = ENT_W'(div_quo) + ENT_W'(1);
            cont_nxt        = '0;
            pos_nxt         = '0;
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = '0;
            state_nxt       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tbl_rdata != '0) begin
          cont_nxt = '0;
          pos_nxt  = pos_r + POS_W'(tbl_rdata);
        end else begin
          cont_nxt = cont_r + ENT_W'(1);
          pos_nxt  = pos_r + POS_W'(1);
        end
        if (cont_nxt == need_r) begin
          state_nxt = S_COMMIT;
        end else if (pos_nxt >= POS_W'(NUM_PAGES)) begin
          res_nxt.status        = ST_NO_SPACE;
          res_nxt.block_address = '0;
          state_nxt             = S_RESP;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = pos_nxt[IDX_W-1:0];
        end
      end
      S_COMMIT: begin
        tbl_req.wr_en         = 1'b1;
        tbl_req.wr_addr       = head;
        tbl_req.wr_data       = need_r;
        res_nxt.status        = ST_OK;
        res_nxt.block_address = base_address + ADR_W'(head_ofs);
        state_nxt             = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    dvd_r  <= dvd_nxt;
    need_r <= need_nxt;
    cont_r <= cont_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

// ===== rtl/ffpa_checker.sv =====
// Port-level checks of the first-fit page allocator, bound to its top level.
// Depends on ffpa_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module ffpa_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ffpa_pkg::out_item_t out_payload
);
  import ffpa_pkg::*;

  `FFPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FFPA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `FFPA_ASSERT_IMP(a_addr_zero_on_fail, out_valid && out_payload.status != ST_OK, out_payload.block_address == '0)
  `FFPA_ASSERT_IMP(a_no_result_after_reset, $past(!rst_n), !out_valid)

endmodule

bind first_fit_page_allocator ffpa_port_checker u_ffpa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);

// ===== dv/ffpa_checker.sv =====
// Checker for the first-fit page allocator: mirrors the run table and registers from the ports.
// It watches the request, result and register ports and counts every mismatch it finds in the results.
// Depends on ffpa_pkg for the transaction types, codes and sizes.
module ffpa_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ffpa_pkg::in_item_t            in_payload,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ffpa_pkg::out_item_t           out_payload,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ffpa_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ffpa_pkg::CFG_DW-1:0]   cfg_pwdata,
  input  logic                          cfg_pready,
  output int unsigned                   mismatch_count,
  output int unsigned                   outstanding
);
  import ffpa_pkg::*;

  logic [ENT_W-1:0] page_runs [NUM_PAGES];
  logic [ADR_W-1:0] region_base;
  logic [PS_W-1:0]  page_bytes;
  out_item_t        expected_replies [$];
  int unsigned      fault_total = 0;

  assign mismatch_count = fault_total;

  function automatic out_item_t predict_reply(in_item_t req);
    out_item_t   res;
    logic [31:0] step;
    logic [31:0] pages;
    logic [31:0] offset;
    logic [31:0] slot;
    int          pos;
    int          run;
    res.status        = ST_NO_SPACE;
    res.block_address = '0;
    step = (page_bytes == '0) ? 32'd1 : 32'(page_bytes);
    if (req.operation == OP_ALLOC) begin
      if (req.request_bytes != '0) begin
        pages = (32'(req.request_bytes) - 32'd1) / step + 32'd1;
        if (pages <= NUM_PAGES) begin
          pos = 0;
          run = 0;
          while (run < pages && pos < NUM_PAGES) begin
            if (page_runs[pos] != '0) begin
              run = 0;
              pos += page_runs[pos];
            end else begin
              run++;
              pos++;
            end
          end
          if (run == pages) begin
            page_runs[pos - run] = ENT_W'(run);
            res.status           = ST_OK;
            res.block_address    = region_base + 32'(pos - run) * step;
          end
        end
      end
    end else begin
      offset = req.release_address - region_base;
      slot   = offset / step;
      if (slot >= NUM_PAGES) begin
        res.status = ST_BAD_ADDRESS;
      end else begin
        page_runs[slot[IDX_W-1:0]] = '0;
        res.status                 = ST_OK;
      end
    end
    return res;
  endfunction

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    fault_total++;
    if (fault_total <= 10) begin
      $display("%0t: %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (page_runs[k]) page_runs[k] = '0;
      region_base = '0;
      page_bytes  = PG_BYTES_RST;
      expected_replies.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[CFG_AW-1:2]))
          REG_BASE_ADDRESS: region_base = cfg_pwdata[ADR_W-1:0];
          REG_PG_BYTES:     page_bytes  = cfg_pwdata[PS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_replies.push_back(predict_reply(in_payload));
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          flag("result transaction with nothing expected", '0, out_payload.block_address);
        end else begin
          want = expected_replies.pop_front();
          if (out_payload.status !== want.status) begin
            flag("status mismatch", 32'(want.status), 32'(out_payload.status));
          end
          if (out_payload.block_address !== want.block_address) begin
            flag("block address mismatch", want.block_address, out_payload.block_address);
          end
        end
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

// ===== dv/tb_first_fit_page_allocator.sv =====
// Top of the page allocator testbench: clock, reset, request and result traffic, and the verdict.
// It depends on ffpa_pkg, the first_fit_page_allocator block and the ffpa_checker module.
module tb_first_fit_page_allocator;
  import ffpa_pkg::*;

  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 80;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_payload;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_payload;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int unsigned       mismatch_count;
  int unsigned       outstanding;

  op_t               issued_ops [$];
  logic [ADR_W-1:0]  held_blocks [$];
  logic [ADR_W-1:0]  cur_base;
  int unsigned       cur_page;
  int unsigned       src_burst = 0;
  int unsigned       idle_cycles = 0;

  first_fit_page_allocator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ffpa_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_payload    (out_payload),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Successful allocations are kept so that later frees can hand them back.
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      issued_ops.push_back(in_payload.operation);
    end
    if (out_valid && out_ready && issued_ops.size() > 0) begin
      if (issued_ops.pop_front() == OP_ALLOC && out_payload.status == ST_OK) begin
        held_blocks.push_back(out_payload.block_address);
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("first_fit_page_allocator regression: fail");
      $finish;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned pause;
    int unsigned burst;
    int unsigned taken;
    out_ready = 1'b0;
    burst     = 0;
    taken     = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300) begin
        pause = 400;
      end else if (burst > 0) begin
        pause = 0;
        burst--;
      end else begin
        pause = $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 50);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  function automatic in_item_t alloc_req(logic [BYTES_W-1:0] bytes);
    in_item_t req;
    req.operation       = OP_ALLOC;
    req.request_bytes   = bytes;
    req.release_address = $urandom();
    return req;
  endfunction

  function automatic in_item_t release_req(logic [ADR_W-1:0] addr);
    in_item_t req;
    req.operation       = OP_FREE;
    req.request_bytes   = BYTES_W'($urandom());
    req.release_address = addr;
    return req;
  endfunction

  task automatic offer(in_item_t req);
    int unsigned gap;
    if (src_burst > 0) begin
      gap = 0;
      src_burst--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) src_burst = $urandom_range(10, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic release_all();
    settle();
    while (held_blocks.size() > 0) offer(release_req(held_blocks.pop_front()));
    settle();
  endtask

  task automatic cfg_write(reg_idx_t which, logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({which, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned pages;
    int          slot;
    logic [ADR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      offer(in_item_t'($bits(in_item_t)'({$urandom(), $urandom()})));
    end else if (pick < 14) begin
      offer(release_req(cur_base + $urandom_range(0, NUM_PAGES * cur_page - 1)));
    end else if (pick < 50 && held_blocks.size() > 0) begin
      slot = $urandom_range(0, held_blocks.size() - 1);
      addr = held_blocks[slot];
      held_blocks.delete(slot);
      offer(release_req(addr + $urandom_range(0, cur_page - 1)));
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 14) pages = $urandom_range(1, 8);
      else if (pick < 18) pages = $urandom_range(9, 32);
      else pages = $urandom_range(33, NUM_PAGES + 1);
      offer(alloc_req(BYTES_W'((pages - 1) * cur_page + $urandom_range(1, cur_page))));
    end
  endtask

  initial begin : stimulus
    logic [ADR_W-1:0] base_plan [PHASES];
    logic [PS_W-1:0]  page_plan [PHASES];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_payload  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cur_base    = '0;
    cur_page    = PG_BYTES_RST;
    base_plan   = '{32'h0, 32'hFFFF_FFC0, 32'hFFFF_F000, 32'h0, 32'hFFFF_FFFF, $urandom(),
                    $urandom()};
    page_plan   = '{PG_BYTES_RST, 13'd0, 13'd4096, 13'd1, 13'd13,
                    PS_W'($urandom_range(1, 4096)), PS_W'($urandom_range(1, 64))};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        release_all();
        cfg_write(REG_BASE_ADDRESS, CFG_DW'(base_plan[ph]));
        cfg_write(REG_PG_BYTES, CFG_DW'(page_plan[ph]));
        cur_base = base_plan[ph];
        cur_page = (page_plan[ph] == '0) ? 1 : page_plan[ph];
      end
      if (ph == 0) begin
        // Reset settings: empty, oversized and exact requests, then a full table.
        offer(alloc_req(20'd0));
        offer(alloc_req(20'hFFFFF));
        offer(alloc_req(20'd1));
        offer(alloc_req(20'd64));
        offer(alloc_req(20'd65));
        offer(release_req(32'd101));
        offer(release_req(32'hFFFF_FFFF));
        offer(release_req(32'd4096));
        offer(release_req(32'd4095));
        offer(alloc_req(20'(61 * 64)));
        offer(alloc_req(20'(60 * 64)));
        offer(alloc_req(20'd64));
        offer(alloc_req(20'd1));
        offer(release_req(32'd0));
        offer(release_req(32'd128));
        offer(release_req(32'd256));
        offer(release_req(32'd64));
        offer(alloc_req(20'd4096));
        offer(release_req(32'd0));
      end else if (ph == 1) begin
        // A page size of zero acts as one byte; the region sits just below the top of memory.
        offer(release_req(32'h0));
        offer(alloc_req(20'd64));
        offer(alloc_req(20'd1));
        offer(release_req(32'hFFFF_FFFF));
        offer(release_req(32'hFFFF_FFBF));
        offer(release_req(32'hFFFF_FFC0));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 100) settle();
        random_request();
      end
    end
    release_all();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("first_fit_page_allocator regression: pass");
    end else begin
      $display("first_fit_page_allocator regression: fail");
    end
    $finish;
  end

endmodule
